[rtl/core/rtpvp8_pkg.sv]
// ----------------------------------------------------------------------------
// rtpvp8_pkg
// Types, parse stage codes and status codes shared by the RTP/VP8 header
// parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpvp8_pkg;

  localparam int unsigned StageBits = 3;

  localparam logic [StageBits-1:0] ST_RTP    = 3'd0;
  localparam logic [StageBits-1:0] ST_DESC   = 3'd1;
  localparam logic [StageBits-1:0] ST_EXT    = 3'd2;
  localparam logic [StageBits-1:0] ST_PIC_HI = 3'd3;
  localparam logic [StageBits-1:0] ST_PIC_LO = 3'd4;
  localparam logic [StageBits-1:0] ST_TL0    = 3'd5;
  localparam logic [StageBits-1:0] ST_TK     = 3'd6;
  localparam logic [StageBits-1:0] ST_DONE   = 3'd7;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_CSRC  = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;

  localparam int unsigned RtpHeaderLast = 11;
  localparam int unsigned ResBits       = 145;
  localparam int unsigned ResPadBits    = 7;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] payload_length;
    logic [4:0]  header_length;
    logic [14:0] picture_id;
    logic [2:0]  partition_index;
    logic [7:0]  descriptor_flags;
    logic [31:0] ssrc;
    logic [31:0] timestamp;
    logic [15:0] seq_num;
    logic [6:0]  ptype_code;
    logic [3:0]  contrib_count;
    logic [4:0]  rtp_flags;
  } res_t;

  function automatic logic [StageBits-1:0] stage_after_pic(input logic [7:0] flags);
    logic [StageBits-1:0] nxt;
    if (flags[3]) begin
      nxt = ST_TL0;
    end else if (flags[2] || flags[1]) begin
      nxt = ST_TK;
    end else begin
      nxt = ST_DONE;
    end
    return nxt;
  endfunction

  function automatic logic [StageBits-1:0] stage_after_ext(input logic [7:0] flags);
    logic [StageBits-1:0] nxt;
    if (flags[4]) begin
      nxt = ST_PIC_HI;
    end else begin
      nxt = stage_after_pic(flags);
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rtpvp8_in_reg.sv]
// ----------------------------------------------------------------------------
// rtpvp8_in_reg
// Input register for the byte stream; holds one byte until the parse stage
// takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpvp8_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

[rtl/core/rtpvp8_parse.sv]
// ----------------------------------------------------------------------------
// rtpvp8_parse
// Parse state and field capture; builds the result for the current byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpvp8_parse #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output rtpvp8_pkg::res_t   res_o
);
  import rtpvp8_pkg::*;

  localparam int unsigned WideBits = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [COUNT_BITS-1:0] pos_q, pos_d, total;
  logic [StageBits-1:0]  stage_q, stage_d;
  logic [4:0]            hend_q, hend_d;
  logic [4:0]            rflags_q, rflags_d;
  logic [3:0]            cc_q, cc_d;
  logic [6:0]            pt_q, pt_d;
  logic [15:0]           seq_q, seq_d;
  logic [31:0]           ts_q, ts_d;
  logic [31:0]           ssrc_q, ssrc_d;
  logic [7:0]            vflags_q, vflags_d;
  logic [2:0]            pidx_q, pidx_d;
  logic [14:0]           pic_q, pic_d;
  logic                  pos_lt11;
  logic [COUNT_BITS-1:0] diff;
  logic [WideBits-1:0]   diff_w;
  logic [15:0]           plen;
  logic [1:0]            status;

  assign pos_lt11 = pos_q < COUNT_BITS'(RtpHeaderLast);
  assign total    = (&pos_q) ? pos_q : pos_q + COUNT_BITS'(1);

  always_comb begin
    stage_d  = stage_q;
    hend_d   = hend_q;
    rflags_d = rflags_q;
    cc_d     = cc_q;
    pt_d     = pt_q;
    seq_d    = seq_q;
    ts_d     = ts_q;
    ssrc_d   = ssrc_q;
    vflags_d = vflags_q;
    pidx_d   = pidx_q;
    pic_d    = pic_q;
    unique case (stage_q)
      ST_RTP: begin
        if (pos_q == COUNT_BITS'(0)) begin
          rflags_d = {byte_i[7:6], byte_i[5], byte_i[4], rflags_q[0]};
          cc_d     = byte_i[3:0];
        end else if (pos_q == COUNT_BITS'(1)) begin
          rflags_d = {rflags_q[4:1], byte_i[7]};
          pt_d     = byte_i[6:0];
        end else if (pos_q < COUNT_BITS'(4)) begin
          seq_d = {seq_q[7:0], byte_i};
        end else if (pos_q < COUNT_BITS'(8)) begin
          ts_d = {ts_q[23:0], byte_i};
        end else begin
          ssrc_d = {ssrc_q[23:0], byte_i};
        end
        hend_d = {1'b0, pos_q[3:0]} + 5'd1;
        if (!pos_lt11) begin
          stage_d = (cc_q != 4'd0) ? ST_DONE : ST_DESC;
        end
      end
      ST_DESC: begin
        vflags_d = {byte_i[7], byte_i[5], byte_i[4], 5'd0};
        pidx_d   = byte_i[2:0];
        hend_d   = hend_q + 5'd1;
        stage_d  = byte_i[7] ? ST_EXT : ST_DONE;
      end
      ST_EXT: begin
        vflags_d = vflags_q | {3'd0, byte_i[7:4], 1'b0};
        hend_d   = hend_q + 5'd1;
        stage_d  = stage_after_ext(vflags_d);
      end
      ST_PIC_HI: begin
        hend_d = hend_q + 5'd1;
        if (byte_i[7]) begin
          vflags_d = vflags_q | 8'h01;
          pic_d    = {byte_i[6:0], 8'd0};
          stage_d  = ST_PIC_LO;
        end else begin
          pic_d   = {8'd0, byte_i[6:0]};
          stage_d = stage_after_pic(vflags_q);
        end
      end
      ST_PIC_LO: begin
        pic_d   = pic_q | {7'd0, byte_i};
        hend_d  = hend_q + 5'd1;
        stage_d = stage_after_pic(vflags_q);
      end
      ST_TL0: begin
        hend_d  = hend_q + 5'd1;
        stage_d = (vflags_q[2] || vflags_q[1]) ? ST_TK : ST_DONE;
      end
      ST_TK: begin
        hend_d  = hend_q + 5'd1;
        stage_d = ST_DONE;
      end
      ST_DONE: begin
        stage_d = ST_DONE;
      end
      default: begin
        stage_d = stage_q;
      end
    endcase
    pos_d = total;
  end

  always_comb begin
    if (pos_lt11) begin
      status = STATUS_SHORT;
    end else if (cc_d != 4'd0) begin
      status = STATUS_CSRC;
    end else if (stage_d != ST_DONE) begin
      status = STATUS_SHORT;
    end else begin
      status = STATUS_OK;
    end
  end

  assign diff   = (total > COUNT_BITS'(hend_d)) ? total - COUNT_BITS'(hend_d) : '0;
  assign diff_w = WideBits'(diff);

  always_comb begin
    if (status == STATUS_SHORT) begin
      plen = 16'd0;
    end else if (diff_w > WideBits'(16'hFFFF)) begin
      plen = 16'hFFFF;
    end else begin
      plen = diff_w[15:0];
    end
  end

  always_comb begin
    res_o.status           = status;
    res_o.payload_length   = plen;
    res_o.header_length    = hend_d;
    res_o.picture_id       = pic_d;
    res_o.partition_index  = pidx_d;
    res_o.descriptor_flags = vflags_d;
    res_o.ssrc             = ssrc_d;
    res_o.timestamp        = ts_d;
    res_o.seq_num          = seq_d;
    res_o.ptype_code       = pt_d;
    res_o.contrib_count    = cc_d;
    res_o.rtp_flags        = rflags_d;
  end

  // drop all packet state once the last byte is parsed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      stage_q  <= ST_RTP;
      hend_q   <= '0;
      rflags_q <= '0;
      cc_q     <= '0;
      pt_q     <= '0;
      seq_q    <= '0;
      ts_q     <= '0;
      ssrc_q   <= '0;
      vflags_q <= '0;
      pidx_q   <= '0;
      pic_q    <= '0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q    <= '0;
        stage_q  <= ST_RTP;
        hend_q   <= '0;
        rflags_q <= '0;
        cc_q     <= '0;
        pt_q     <= '0;
        seq_q    <= '0;
        ts_q     <= '0;
        ssrc_q   <= '0;
        vflags_q <= '0;
        pidx_q   <= '0;
        pic_q    <= '0;
      end else begin
        pos_q    <= pos_d;
        stage_q  <= stage_d;
        hend_q   <= hend_d;
        rflags_q <= rflags_d;
        cc_q     <= cc_d;
        pt_q     <= pt_d;
        seq_q    <= seq_d;
        ts_q     <= ts_d;
        ssrc_q   <= ssrc_d;
        vflags_q <= vflags_d;
        pidx_q   <= pidx_d;
        pic_q    <= pic_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/rtpvp8_out_reg.sv]
// ----------------------------------------------------------------------------
// rtpvp8_out_reg
// Result register; holds one parsed header until the downstream takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpvp8_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  rtpvp8_pkg::res_t res_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output rtpvp8_pkg::res_t res_o
);
  import rtpvp8_pkg::*;

  logic valid_q;
  res_t res_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

[rtl/core/rtp_vp8_header_parser_core.sv]
// ----------------------------------------------------------------------------
// rtp_vp8_header_parser_core
// Parses the RTP fixed header and VP8 payload descriptor of a byte stream
// and emits one header request per packet on its last byte.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained across packet boundaries; the
//   last byte of a packet waits while the result register holds a request.
// Path: the last byte of a packet passes through the input register, then
//   the parse logic into the result register, which offers its header request.
// Reset: asynchronous, active low; clears all parse state and the valid flags of both registers.
`default_nettype none

module rtp_vp8_header_parser_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] packet_byte
  input  logic         s_axis_tlast,  // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [4:0] rtp_flags, [8:5] contrib_count, [15:9] ptype_code,
  // [31:16] seq_num, [63:32] timestamp, [95:64] ssrc,
  // [103:96] descriptor_flags, [106:104] partition_index,
  // [121:107] picture_id, [126:122] header_length,
  // [142:127] payload_length, [144:143] status, [151:145] zero
  output logic [151:0] m_axis_tdata
);
  import rtpvp8_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_free;
  logic       step;
  res_t       res_next;
  res_t       res_out;

  // advance a byte unless it closes a packet and the result slot is busy
  assign step = in_valid && (!in_last || out_free);

  rtpvp8_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .take_i  (step),
    .valid_o (in_valid),
    .byte_o  (in_byte),
    .last_o  (in_last)
  );

  rtpvp8_parse #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte),
    .last_i (in_last),
    .res_o  (res_next)
  );

  rtpvp8_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && in_last),
    .res_i   (res_next),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {ResPadBits'(0), res_out};

  a_ok_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_out.status == STATUS_OK
      |-> res_out.header_length >= 5'd13 && res_out.header_length <= 5'd18)
    else $error("ok header with bad header length");

  a_csrc_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_out.status == STATUS_CSRC
      |-> res_out.header_length == 5'd12 && res_out.contrib_count != 4'd0)
    else $error("csrc request with bad header length or count");

  a_short_plen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_out.status == STATUS_SHORT |-> res_out.payload_length == 16'd0)
    else $error("short packet with nonzero payload length");

  a_no_loss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("pending header request dropped");

endmodule

`default_nettype wire
